FILE: rtl/core/snor_pkg.sv
// Shared constants for the SPI NOR flash command engine: widths, reset values,
// configuration register indexes and command opcodes.
// No dependencies.
`default_nettype none

package snor_pkg;

  localparam int ADDR_W    = 25;
  localparam int ID_W      = 24;
  localparam int SIZE_W    = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 24;

  localparam int STORE_BYTES_DEF  = 65536;
  localparam int SECTOR_BYTES_DEF = 4096;
  localparam int PAGE_BYTES_DEF   = 256;

  localparam logic [SIZE_W-1:0] FLASH_SIZE_RST = 17'd65536;
  localparam logic [ID_W-1:0]   JEDEC_RST      = 24'hEF3015;

  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JEDEC      = 1'd1;

  localparam logic [7:0] OP_JEDEC = 8'h9F;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_WRDI  = 8'h04;
  localparam logic [7:0] OP_SE    = 8'h20;
  localparam logic [7:0] OP_PP    = 8'h02;
  localparam logic [7:0] OP_READ  = 8'h03;

  localparam logic [7:0] ERASED_BYTE = 8'hFF;

endpackage

`default_nettype wire

FILE: rtl/core/spi_nor_flash_command_engine.sv
// Top level of the SPI NOR flash command engine: configuration registers,
// input and output handshakes, sequencer and flash array.
// Depends on snor_pkg, snor_store and snor_seq.
//
// Usage. Each input transfer (action, tx_byte) is one byte exchanged on the
// SPI bus (action 0) or a chip-select release (action 1). Every input transfer
// produces exactly one output transfer carrying rx_byte, in order.
// Supported commands: JEDEC ID, read status, write enable/disable, sector
// erase, page program and read, with 24-bit addresses sent high byte first.
//
// Timing. An item is taken in the cycle after the previous one has been
// handed to the output register. Most items are decoded and then posted to
// the output register; a read or program data byte also passes through the
// flash array's registered read in between. A sector erase writes one byte
// of 0xFF per cycle between decode and post, over the bytes erased
// (SECTOR_BYTES, or fewer for a short last sector).
//
// Reset. After rst the engine sweeps the whole array to 0xFF, one byte per
// cycle; in_stall is high during the sweep, while configuration writes are
// taken as usual.
//
// Backpressure. The output register holds a result while out_stall is high,
// and the engine may accept and decode the next item meanwhile; it then waits
// with that result until the output register frees up.
`default_nettype none

module spi_nor_flash_command_engine #(
  parameter int STORE_BYTES  = snor_pkg::STORE_BYTES_DEF,
  parameter int SECTOR_BYTES = snor_pkg::SECTOR_BYTES_DEF,
  parameter int PAGE_BYTES   = snor_pkg::PAGE_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [7:0]                     tx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     rx_byte,
  input  logic                           cfg_we,
  input  logic [snor_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [snor_pkg::CFG_W-1:0]     cfg_data
);

  import snor_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [ADDR_W-1:0] STORE_SPAN = ADDR_W'(STORE_BYTES);

  // Configuration registers.
  logic [SIZE_W-1:0] flash_size;
  logic [ID_W-1:0]   jedec_identity;

  // The size in effect is the configured size clamped to the array depth.
  logic [ADDR_W-1:0] size_cfg;
  logic [ADDR_W-1:0] size_eff;

  logic          seq_ready;
  logic          in_fire;
  logic          post_valid;
  logic          post_ok;
  logic [7:0]    post_byte;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_size     <= FLASH_SIZE_RST;
      jedec_identity <= JEDEC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FLASH_SIZE: flash_size <= cfg_data[SIZE_W-1:0];
        CFG_JEDEC:      jedec_identity <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  assign size_cfg = {{(ADDR_W-SIZE_W){1'b0}}, flash_size};
  assign size_eff = (size_cfg < STORE_SPAN) ? size_cfg : STORE_SPAN;

  // Input side: the sequencer takes a transfer only when it is between items.
  assign in_stall = !seq_ready;
  assign in_fire  = in_valid && seq_ready;

  // Output register: a new result may be loaded when the slot is empty or
  // its current contents are being transferred in this cycle.
  assign post_ok = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (post_valid && post_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post_valid && post_ok) begin
      rx_byte <= post_byte;
    end
  end

  snor_seq #(
    .STORE_BYTES  (STORE_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .in_action  (action),
    .in_tx      (tx_byte),
    .ready      (seq_ready),
    .size_eff   (size_eff),
    .identity   (jedec_identity),
    .post_ok    (post_ok),
    .post_valid (post_valid),
    .post_byte  (post_byte),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  snor_store #(
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/core/snor_store.sv
// Byte-wide flash array: one synchronous write port and one read port with
// registered read data. No dependencies.
`default_nettype none

module snor_store #(
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/snor_seq.sv
// Command sequencer: decodes the byte stream, keeps the command phase and the
// write-enable latch, and runs reads, programs, sector erases and the reset
// clear pass against the flash array. Depends on snor_pkg.
`default_nettype none

module snor_seq #(
  parameter int STORE_BYTES  = 65536,
  parameter int SECTOR_BYTES = 4096,
  parameter int PAGE_BYTES   = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_fire,
  input  logic                           in_action,
  input  logic [7:0]                     in_tx,
  output logic                           ready,
  input  logic [snor_pkg::ADDR_W-1:0]    size_eff,
  input  logic [snor_pkg::ID_W-1:0]      identity,
  input  logic                           post_ok,
  output logic                           post_valid,
  output logic [7:0]                     post_byte,
  output logic                           mem_we,
  output logic [$clog2(STORE_BYTES)-1:0] mem_waddr,
  output logic [7:0]                     mem_wdata,
  output logic                           mem_re,
  output logic [$clog2(STORE_BYTES)-1:0] mem_raddr,
  input  logic [7:0]                     mem_rdata
);

  import snor_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [AW-1:0]     CLR_LAST   = AW'(STORE_BYTES - 1);
  localparam logic [ADDR_W-1:0] SECT_SPAN  = ADDR_W'(SECTOR_BYTES);
  localparam logic [ADDR_W-1:0] SECT_MASK  = ~(ADDR_W'(SECTOR_BYTES) - 25'd1);
  localparam logic [ADDR_W-1:0] PAGE_SPAN  = ADDR_W'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PAGE_MASK  = ~(ADDR_W'(PAGE_BYTES) - 25'd1);
  localparam logic [ADDR_W-1:0] ALL_ONES25 = '1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_RDATA = 3'd3;
  localparam logic [2:0] ST_ERASE = 3'd4;
  localparam logic [2:0] ST_POST  = 3'd5;

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_ID0       = 5'd1;
  localparam logic [4:0] PH_ID1       = 5'd2;
  localparam logic [4:0] PH_ID2       = 5'd3;
  localparam logic [4:0] PH_STATUS    = 5'd4;
  localparam logic [4:0] PH_RD_A0     = 5'd5;
  localparam logic [4:0] PH_RD_A1     = 5'd6;
  localparam logic [4:0] PH_RD_A2     = 5'd7;
  localparam logic [4:0] PH_RD_STREAM = 5'd8;
  localparam logic [4:0] PH_PP_A0     = 5'd9;
  localparam logic [4:0] PH_PP_A1     = 5'd10;
  localparam logic [4:0] PH_PP_A2     = 5'd11;
  localparam logic [4:0] PH_PP_STREAM = 5'd12;
  localparam logic [4:0] PH_SE_A0     = 5'd13;
  localparam logic [4:0] PH_SE_A1     = 5'd14;
  localparam logic [4:0] PH_SE_A2     = 5'd15;

  logic [2:0]        st, st_next;
  logic [4:0]        phase, phase_next;
  logic              wel, wel_next;
  logic [ID_W-1:0]   cmd_addr, cmd_addr_next;
  logic [ADDR_W-1:0] op_addr, op_addr_next;
  logic [ADDR_W-1:0] page_limit, page_limit_next;
  logic              act_q, act_q_next;
  logic [7:0]        tx_q, tx_q_next;
  logic [7:0]        res, res_next;
  logic              rd_mode, rd_mode_next;
  logic [AW-1:0]     pp_addr, pp_addr_next;
  logic [ADDR_W-1:0] er_idx, er_idx_next;
  logic [ADDR_W-1:0] er_end, er_end_next;
  logic [AW-1:0]     clr_idx, clr_idx_next;

  logic [ADDR_W-1:0] a_full;
  logic              op_ok;
  logic              se_ok;
  logic [ADDR_W-1:0] se_base;
  logic [ADDR_W-1:0] se_top;
  logic [ADDR_W-1:0] se_end;
  logic [ADDR_W-1:0] pp_page;
  logic [ADDR_W-1:0] op_inc;
  logic [ADDR_W-1:0] er_inc;

  assign a_full  = {1'b0, cmd_addr[23:8], tx_q};
  assign op_ok   = op_addr < size_eff;
  assign se_ok   = a_full < size_eff;
  assign se_base = a_full & SECT_MASK;
  assign se_top  = se_base + SECT_SPAN;
  assign se_end  = (se_top > size_eff) ? size_eff : se_top;
  assign pp_page = (a_full & PAGE_MASK) + PAGE_SPAN;
  assign op_inc  = op_addr + 25'd1;
  assign er_inc  = er_idx + 25'd1;

  assign ready     = (st == ST_IDLE);
  assign post_byte = res;

  always_comb begin
    st_next         = st;
    phase_next      = phase;
    wel_next        = wel;
    cmd_addr_next   = cmd_addr;
    op_addr_next    = op_addr;
    page_limit_next = page_limit;
    act_q_next      = act_q;
    tx_q_next       = tx_q;
    res_next        = res;
    rd_mode_next    = rd_mode;
    pp_addr_next    = pp_addr;
    er_idx_next     = er_idx;
    er_end_next     = er_end;
    clr_idx_next    = clr_idx;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = ERASED_BYTE;
    mem_re          = 1'b0;
    mem_raddr       = op_addr[AW-1:0];
    post_valid      = 1'b0;

    case (st)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == CLR_LAST) begin
          st_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          act_q_next = in_action;
          tx_q_next  = in_tx;
          st_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_next = 8'd0;
        st_next  = ST_POST;
        if (act_q) begin
          if (phase == PH_PP_STREAM) begin
            page_limit_next = ALL_ONES25;
            wel_next        = 1'b0;
          end
          phase_next = PH_IDLE;
        end else begin
          case (phase)
            PH_IDLE: begin
              case (tx_q)
                OP_JEDEC: phase_next = PH_ID0;
                OP_RDSR:  phase_next = PH_STATUS;
                OP_WREN:  wel_next = 1'b1;
                OP_WRDI:  wel_next = 1'b0;
                OP_SE: begin
                  cmd_addr_next = '0;
                  phase_next    = PH_SE_A0;
                end
                OP_PP: begin
                  cmd_addr_next = '0;
                  phase_next    = PH_PP_A0;
                end
                OP_READ: begin
                  cmd_addr_next = '0;
                  phase_next    = PH_RD_A0;
                end
                default: ;
              endcase
            end
            PH_ID0: begin
              res_next   = identity[23:16];
              phase_next = PH_ID1;
            end
            PH_ID1: begin
              res_next   = identity[15:8];
              phase_next = PH_ID2;
            end
            PH_ID2: begin
              res_next   = identity[7:0];
              phase_next = PH_IDLE;
            end
            PH_STATUS: res_next = {6'd0, wel, 1'b0};
            PH_RD_A0, PH_PP_A0, PH_SE_A0: begin
              cmd_addr_next = {tx_q, 16'd0};
              phase_next    = phase + 5'd1;
            end
            PH_RD_A1, PH_PP_A1, PH_SE_A1: begin
              cmd_addr_next = {cmd_addr[23:16], tx_q, 8'd0};
              phase_next    = phase + 5'd1;
            end
            PH_RD_A2: begin
              cmd_addr_next = a_full[ID_W-1:0];
              op_addr_next  = a_full;
              phase_next    = PH_RD_STREAM;
            end
            PH_RD_STREAM: begin
              if (op_ok) begin
                mem_re       = 1'b1;
                op_addr_next = op_inc;
                rd_mode_next = 1'b1;
                st_next      = ST_RDATA;
              end else begin
                res_next = ERASED_BYTE;
              end
            end
            PH_PP_A2: begin
              cmd_addr_next   = a_full[ID_W-1:0];
              op_addr_next    = a_full;
              page_limit_next = pp_page;
              phase_next      = PH_PP_STREAM;
            end
            PH_PP_STREAM: begin
              // The byte is merged only with the latch set, inside the size in use
              // and below the end of the page; otherwise it is dropped.
              if (wel && op_ok && (op_addr < page_limit)) begin
                mem_re       = 1'b1;
                pp_addr_next = op_addr[AW-1:0];
                op_addr_next = op_inc;
                rd_mode_next = 1'b0;
                st_next      = ST_RDATA;
              end
            end
            PH_SE_A2: begin
              cmd_addr_next = a_full[ID_W-1:0];
              phase_next    = PH_IDLE;
              if (wel && se_ok) begin
                er_idx_next = se_base;
                er_end_next = se_end;
                wel_next    = 1'b0;
                st_next     = ST_ERASE;
              end
            end
            default: phase_next = PH_IDLE;
          endcase
        end
      end
      ST_RDATA: begin
        if (rd_mode) begin
          res_next = mem_rdata;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pp_addr;
          mem_wdata = mem_rdata & tx_q;
        end
        st_next = ST_POST;
      end
      ST_ERASE: begin
        mem_we      = 1'b1;
        mem_waddr   = er_idx[AW-1:0];
        er_idx_next = er_inc;
        if (er_inc >= er_end) begin
          st_next = ST_POST;
        end
      end
      ST_POST: begin
        post_valid = 1'b1;
        if (post_ok) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= ST_CLEAR;
      phase      <= PH_IDLE;
      wel        <= 1'b0;
      cmd_addr   <= '0;
      op_addr    <= '0;
      page_limit <= ALL_ONES25;
      clr_idx    <= '0;
    end else begin
      st         <= st_next;
      phase      <= phase_next;
      wel        <= wel_next;
      cmd_addr   <= cmd_addr_next;
      op_addr    <= op_addr_next;
      page_limit <= page_limit_next;
      clr_idx    <= clr_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    act_q   <= act_q_next;
    tx_q    <= tx_q_next;
    res     <= res_next;
    rd_mode <= rd_mode_next;
    pp_addr <= pp_addr_next;
    er_idx  <= er_idx_next;
    er_end  <= er_end_next;
  end

`ifndef ASSERT_OFF
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (op_addr < size_eff))
    else $error("array read issued outside the size in use");

  a_read_then_data: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> (st == ST_RDATA))
    else $error("array read not followed by its data cycle");

  a_erase_bounded: assert property (@(posedge clk) disable iff (rst)
    (st == ST_ERASE) |-> ((er_idx < er_end) && (er_idx < size_eff)))
    else $error("erase sweep ran past its sector end");

  a_one_port_use: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("array written and read in the same cycle");

  a_no_wel_after_erase: assert property (@(posedge clk) disable iff (rst)
    ((st == ST_EXEC) && (st_next == ST_ERASE)) |=> !wel)
    else $error("write-enable latch kept after an accepted erase");
`endif

endmodule

`default_nettype wire

FILE: test/tb_spi_nor_flash_command_engine.sv
// Self-checking testbench for spi_nor_flash_command_engine: a directed table of
// bus transfers, then random command sequences checked against a flash model.
// Depends on snor_pkg and the engine RTL.

module tb_spi_nor_flash_command_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import snor_pkg::*;

  // Sizes of the default build, and bit 1 of the status register (write enable latch).
  localparam int unsigned STORE_B  = STORE_BYTES_DEF;
  localparam int unsigned SECTOR_B = SECTOR_BYTES_DEF;
  localparam logic [ADDR_W-1:0] PAGE_SPAN = ADDR_W'(PAGE_BYTES_DEF);
  localparam logic [7:0] WEL = 8'h02;
  localparam int HOLD_CYCLES = 300;

  // Where the engine stands within one chip-select frame.
  typedef enum logic [4:0] {
    S_IDLE, S_ID0, S_ID1, S_ID2, S_STATUS,
    S_RD_A0, S_RD_A1, S_RD_A2, S_RD_DATA,
    S_PP_A0, S_PP_A1, S_PP_A2, S_PP_DATA,
    S_SE_A0, S_SE_A1, S_SE_A2
  } frame_state_t;

  // Receiver behavior, one mode at a time, picked at random by the receiver.
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_HEAVY} stall_mode_t;

  // One directed transfer. When known is set, rx is the byte the engine must return;
  // otherwise the flash model decides.
  typedef struct packed {
    logic       act;
    logic [7:0] tx;
    logic       known;
    logic [7:0] rx;
  } dir_row_t;

  localparam int DIR_N = 25;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // Identity read straight after reset: three bytes, high first, then idle again.
    '{1'b0, OP_JEDEC, 1'b1, 8'h00},
    '{1'b0, 8'h00,    1'b1, JEDEC_RST[23:16]},
    '{1'b0, 8'hFF,    1'b1, JEDEC_RST[15:8]},
    '{1'b0, 8'h55,    1'b1, JEDEC_RST[7:0]},
    // Set the latch and read status back; it repeats until the release.
    '{1'b0, OP_WREN,  1'b1, 8'h00},
    '{1'b0, OP_RDSR,  1'b1, 8'h00},
    '{1'b0, 8'h00,    1'b1, WEL},
    '{1'b0, 8'hAA,    1'b1, WEL},
    '{1'b1, 8'hFF,    1'b1, 8'h00},
    // Unknown opcode is ignored.
    '{1'b0, 8'hFF,    1'b1, 8'h00},
    // Page program at the last two bytes of page 0; the third byte hits the page end.
    '{1'b0, OP_PP,    1'b1, 8'h00},
    '{1'b0, 8'h00,    1'b1, 8'h00},
    '{1'b0, 8'h00,    1'b1, 8'h00},
    '{1'b0, 8'hFE,    1'b1, 8'h00},
    '{1'b0, 8'h00,    1'b1, 8'h00},
    '{1'b0, 8'h5A,    1'b1, 8'h00},
    '{1'b0, 8'h00,    1'b1, 8'h00},
    '{1'b1, 8'h00,    1'b1, 8'h00},
    // Read the same bytes back, running into the untouched next page.
    '{1'b0, OP_READ,  1'b1, 8'h00},
    '{1'b0, 8'h00,    1'b1, 8'h00},
    '{1'b0, 8'h00,    1'b1, 8'h00},
    '{1'b0, 8'hFE,    1'b1, 8'h00},
    '{1'b0, 8'h00,    1'b0, 8'h00},
    '{1'b0, 8'h00,    1'b0, 8'h00},
    '{1'b0, 8'h00,    1'b0, 8'h00}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [7:0] tx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] rx_byte;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FLASH_SIZE;
  logic [CFG_W-1:0] cfg_data = '0;

  spi_nor_flash_command_engine DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .tx_byte(tx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .rx_byte(rx_byte),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Bytes the engine owes the host, oldest first.
  logic [7:0] rx_due_q [$];
  logic [7:0] rx_want;
  int err_count = 0;
  int sent_count = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  // Flash model state: configuration, frame state, status, address registers and array.
  logic [SIZE_W-1:0] fl_size = FLASH_SIZE_RST;
  logic [ID_W-1:0]   fl_ident = JEDEC_RST;
  frame_state_t      fl_state = S_IDLE;
  logic [7:0]        fl_status = 8'h00;
  logic [23:0]       fl_latch = 24'h0;
  logic [ADDR_W-1:0] fl_ptr = '0;
  logic [ADDR_W-1:0] fl_page_end = '1;
  logic [7:0]        fl_mem [STORE_B];

  initial begin
    foreach (fl_mem[i]) fl_mem[i] = ERASED_BYTE;
  end

  // The size the engine honors: the register, clamped to the array.
  function automatic int unsigned bytes_in_use();
    return (int'(fl_size) < STORE_B) ? int'(fl_size) : STORE_B;
  endfunction

  function automatic bit addr_valid(input logic [ADDR_W-1:0] a);
    return int'(a) < bytes_in_use();
  endfunction

  // Advance the flash model by one transfer and return the byte shifted back.
  function automatic logic [7:0] flash_predict(input logic act, input logic [7:0] tx);
    logic [7:0] rx;
    int unsigned base, stop;
    rx = 8'h00;
    if (act) begin
      // A release ends any frame; only an open program frame drops the latch.
      if (fl_state == S_PP_DATA) begin
        fl_page_end = '1;
        fl_status &= ~WEL;
      end
      fl_state = S_IDLE;
      return 8'h00;
    end
    case (fl_state)
      S_IDLE: begin
        case (tx)
          OP_JEDEC: fl_state = S_ID0;
          OP_RDSR:  fl_state = S_STATUS;
          OP_WREN:  fl_status |= WEL;
          OP_WRDI:  fl_status &= ~WEL;
          OP_SE: begin fl_latch = '0; fl_state = S_SE_A0; end
          OP_PP: begin fl_latch = '0; fl_state = S_PP_A0; end
          OP_READ: begin fl_latch = '0; fl_state = S_RD_A0; end
          default: ;
        endcase
      end
      S_ID0: begin rx = fl_ident[23:16]; fl_state = S_ID1; end
      S_ID1: begin rx = fl_ident[15:8]; fl_state = S_ID2; end
      S_ID2: begin rx = fl_ident[7:0]; fl_state = S_IDLE; end
      S_STATUS: rx = fl_status;
      S_RD_A0: begin fl_latch = {tx, 16'h0}; fl_state = S_RD_A1; end
      S_PP_A0: begin fl_latch = {tx, 16'h0}; fl_state = S_PP_A1; end
      S_SE_A0: begin fl_latch = {tx, 16'h0}; fl_state = S_SE_A1; end
      S_RD_A1: begin fl_latch[15:8] = tx; fl_state = S_RD_A2; end
      S_PP_A1: begin fl_latch[15:8] = tx; fl_state = S_PP_A2; end
      S_SE_A1: begin fl_latch[15:8] = tx; fl_state = S_SE_A2; end
      S_RD_A2: begin
        fl_latch[7:0] = tx;
        fl_ptr = {1'b0, fl_latch};
        fl_state = S_RD_DATA;
      end
      S_RD_DATA: begin
        // Out of range reads float high and leave the pointer where it is.
        if (addr_valid(fl_ptr)) begin
          rx = fl_mem[fl_ptr[15:0]];
          fl_ptr = fl_ptr + 1'b1;
        end else begin
          rx = ERASED_BYTE;
        end
      end
      S_PP_A2: begin
        fl_latch[7:0] = tx;
        fl_ptr = {1'b0, fl_latch};
        fl_page_end = ({1'b0, fl_latch} & ~(PAGE_SPAN - 1'b1)) + PAGE_SPAN;
        fl_state = S_PP_DATA;
      end
      S_PP_DATA: begin
        // Programming only clears bits, and stops at the page end.
        if ((fl_status & WEL) != 0 && addr_valid(fl_ptr) && fl_ptr < fl_page_end) begin
          fl_mem[fl_ptr[15:0]] &= tx;
          fl_ptr = fl_ptr + 1'b1;
        end
      end
      S_SE_A2: begin
        fl_latch[7:0] = tx;
        fl_state = S_IDLE;
        if ((fl_status & WEL) != 0 && addr_valid({1'b0, fl_latch})) begin
          base = int'(fl_latch) & ~(SECTOR_B - 1);
          stop = base + SECTOR_B;
          if (stop > bytes_in_use()) stop = bytes_in_use();
          for (int unsigned i = base; i < stop; i++) fl_mem[i] = ERASED_BYTE;
          fl_status &= ~WEL;
        end
      end
      default: fl_state = S_IDLE;
    endcase
    return rx;
  endfunction

  // Offer one transfer and hold it until the engine takes it. The sender works in
  // bursts; between bursts valid drops for a random gap, and some bursts follow
  // each other without a gap.
  task automatic send_byte(input logic act, input logic [7:0] tx,
                           input logic known = 1'b0, input logic [7:0] known_rx = 8'h00);
    int gap;
    logic [7:0] rx;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    action <= act;
    tx_byte <= tx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // The transfer happened at this edge; the model steps in the same order.
    rx = flash_predict(act, tx);
    rx_due_q.push_back(known ? known_rx : rx);
    sent_count++;
  endtask

  task automatic send_addr(input logic [23:0] a);
    send_byte(1'b0, a[23:16]);
    send_byte(1'b0, a[15:8]);
    send_byte(1'b0, a[7:0]);
  endtask

  // Addresses cluster on a small region so that programs and erases are read back,
  // with some near page ends, near the size limit and anywhere in the 24-bit space.
  function automatic logic [23:0] pick_addr();
    int unsigned lim;
    lim = bytes_in_use();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 24'($urandom_range(0, 1023));
      5, 6: return {8'h00, 8'($urandom_range(0, 255)), 8'($urandom_range(248, 255))};
      7: return (lim > 8) ? 24'(lim - $urandom_range(1, 8)) : 24'($urandom_range(0, 15));
      8: return 24'($urandom);
      default: return 24'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly well-formed frames with random content; a few frames are cut short and
  // some transfers are plain noise.
  task automatic run_random(input int items);
    int target, pick, n;
    logic [7:0] op;
    target = sent_count + items;
    while (sent_count < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_byte(1'b0, OP_JEDEC);
        repeat (3) send_byte(1'b0, 8'($urandom));
        if ($urandom_range(0, 3) != 0) send_byte(1'b1, 8'($urandom));
      end else if (pick < 20) begin
        send_byte(1'b0, OP_RDSR);
        repeat ($urandom_range(1, 4)) send_byte(1'b0, 8'($urandom));
        send_byte(1'b1, 8'($urandom));
      end else if (pick < 32) begin
        send_byte(1'b0, OP_WREN);
        if ($urandom_range(0, 1) == 0) send_byte(1'b1, 8'($urandom));
      end else if (pick < 37) begin
        send_byte(1'b0, OP_WRDI);
      end else if (pick < 41) begin
        // Erases are slow, so they stay rare.
        if ($urandom_range(0, 4) != 0) send_byte(1'b0, OP_WREN);
        send_byte(1'b0, OP_SE);
        send_addr(pick_addr());
        send_byte(1'b1, 8'($urandom));
      end else if (pick < 66) begin
        if ($urandom_range(0, 6) != 0) begin
          send_byte(1'b0, OP_WREN);
          send_byte(1'b1, 8'($urandom));
        end
        send_byte(1'b0, OP_PP);
        send_addr(pick_addr());
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        repeat (n) send_byte(1'b0, 8'($urandom));
        if ($urandom_range(0, 9) != 0) send_byte(1'b1, 8'($urandom));
      end else if (pick < 92) begin
        send_byte(1'b0, OP_READ);
        send_addr(pick_addr());
        repeat ($urandom_range(1, 12)) send_byte(1'b0, 8'($urandom));
        send_byte(1'b1, 8'($urandom));
      end else if (pick < 96) begin
        // Address phase cut off by a release.
        case ($urandom_range(0, 2))
          0: op = OP_SE;
          1: op = OP_PP;
          default: op = OP_READ;
        endcase
        send_byte(1'b0, op);
        repeat ($urandom_range(0, 2)) send_byte(1'b0, 8'($urandom));
        send_byte(1'b1, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(1'($urandom), 8'($urandom));
      end
    end
    // Close whatever frame is open so each phase ends idle.
    send_byte(1'b1, 8'($urandom));
  endtask

  // Stop offering and wait for every owed byte.
  task automatic drain();
    in_valid <= 1'b0;
    while (rx_due_q.size() != 0) @(posedge clk);
  endtask

  // Write both registers on consecutive edges; the engine is idle here.
  task automatic set_config(input logic [SIZE_W-1:0] size, input logic [ID_W-1:0] ident);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FLASH_SIZE;
    cfg_data <= CFG_W'(size);
    @(posedge clk);
    cfg_index <= CFG_JEDEC;
    cfg_data <= CFG_W'(ident);
    @(posedge clk);
    cfg_we <= 1'b0;
    fl_size = size;
    fl_ident = ident;
  endtask

  // Receiver: a stall pattern that changes its mode at random intervals, and
  // once a long hold-off during which the sender keeps offering, so that the
  // engine backs up and stalls its input.
  initial begin : receiver
    stall_mode_t mode;
    int mode_left;
    int tick;
    mode = RX_FREE;
    mode_left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        tick++;
        case (mode)
          RX_FREE:     out_stall <= 1'b0;
          RX_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
          RX_PERIODIC: out_stall <= (tick % 4 != 0);
          default:     out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // Every output transfer is matched against the oldest owed byte.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (rx_due_q.size() == 0) begin
        $display("%0t: rx_byte expected none, actual %02h", $time, rx_byte);
        err_count++;
      end else begin
        rx_want = rx_due_q.pop_front();
        if (rx_byte !== rx_want) begin
          $display("%0t: rx_byte expected %02h, actual %02h", $time, rx_want, rx_byte);
          err_count++;
        end
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset values: the directed table, then random traffic with one long hold-off.
    // The engine clears its array after reset and holds in_stall until done.
    for (int i = 0; i < DIR_N; i++)
      send_byte(DIR_ROWS[i].act, DIR_ROWS[i].tx, DIR_ROWS[i].known, DIR_ROWS[i].rx);
    send_byte(1'b1, 8'h00, 1'b1, 8'h00);
    hold_req = 1'b1;
    run_random(250);
    drain();

    // Size just past one sector, so the last sector is short; identity all zeros.
    set_config(17'(SECTOR_B + 300), 24'h000000);
    run_random(200);
    drain();

    // Zero size: every address is out of range; identity all ones.
    set_config(17'd0, 24'hFFFFFF);
    run_random(100);
    drain();

    // Largest register value, clamped to the array; random identity.
    set_config(17'h1FFFF, 24'($urandom));
    run_random(250);
    drain();

    // Back to the full array with another identity.
    set_config(17'(STORE_B), 24'($urandom));
    run_random(250);
    drain();

    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_spi_nor_flash_command_engine: done, clean");
    end else begin
      $display("tb_spi_nor_flash_command_engine: done, errors");
    end
    $finish;
  end

  // Covers the array clear after reset, rare erases and all stalls many times over.
  initial begin : watchdog
    #20_000_000;
    $display("tb_spi_nor_flash_command_engine: done, errors");
    $finish;
  end

endmodule
